/* sv/jtm_pkg.sv */
// Shared types, character codes and capture-update functions for the
// joystick text to motor PWM block. No dependencies.
package jtm_pkg;

	localparam int FRAME_BYTES     = 26;
	localparam int START_POSITIONS = 20;
	localparam int TURN_START_LIM  = START_POSITIONS + 2;
	localparam int POS_W           = 5;
	localparam int VALUE_W         = 10;
	localparam int PWM_W           = 11;
	localparam int VALUE_MAX       = 999;
	localparam int PWM_FULL        = 2000;
	localparam int PWM_SCALE       = 20;
	localparam int SPEED_LIMIT     = 100;
	localparam int TURN_LIMIT      = 100;
	localparam int OUT_W           = 48;

	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] DIGIT_MASK = 8'h0f;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SIGN   = 3'd1,
		PH_FIRST  = 3'd2,
		PH_SECOND = 3'd3,
		PH_THIRD  = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic [VALUE_W-1:0]   acc;
		logic                 sign;
	} cap_t;

	typedef struct packed {
		logic [VALUE_W-1:0] turn;
		logic [VALUE_W-1:0] speed;
		logic               turn_pos;
		logic               speed_pos;
	} frame_t;

	function automatic logic [VALUE_W-1:0] digit_of(input logic [7:0] b);
		logic [7:0] d;
		d = b & DIGIT_MASK;
		return VALUE_W'(d);
	endfunction

	function automatic logic [VALUE_W-1:0] add_digit(input logic [VALUE_W-1:0] acc,
		input logic [7:0] b);
		logic [13:0] v;
		v = 14'(acc) * 14'd10 + 14'(digit_of(b));
		return (v > 14'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX) : v[VALUE_W-1:0];
	endfunction

	function automatic cap_t cap_feed(input cap_t c, input logic [7:0] b);
		cap_t r;
		r = c;
		case (c.phase)
			PH_SIGN: begin
				if (b == CH_MINUS) begin
					r.sign  = 1'b0;
					r.phase = PH_FIRST;
				end else begin
					r.sign  = 1'b1;
					r.acc   = digit_of(b);
					r.phase = PH_SECOND;
				end
			end
			PH_FIRST: begin
				r.acc   = digit_of(b);
				r.phase = PH_SECOND;
			end
			PH_SECOND: begin
				if (b == CH_DOT) begin
					r.phase = PH_IDLE;
				end else begin
					r.acc   = add_digit(c.acc, b);
					r.phase = PH_THIRD;
				end
			end
			PH_THIRD: begin
				if (b != CH_DOT)
					r.acc = add_digit(c.acc, b);
				r.phase = PH_IDLE;
			end
			default: r.phase = PH_IDLE;
		endcase
		return r;
	endfunction

	// closes an open capture as if '.' bytes followed
	function automatic cap_t cap_finish(input cap_t c);
		cap_t r;
		r = c;
		case (c.phase)
			PH_SIGN: begin
				r.sign = 1'b1;
				r.acc  = digit_of(CH_DOT);
			end
			PH_FIRST: r.acc = digit_of(CH_DOT);
			default: ;
		endcase
		r.phase = PH_IDLE;
		return r;
	endfunction

endpackage

/* sv/jtm_parse.sv */
// Input register and byte-wise frame parser: tracks the "acc" header and the
// turn and speed captures. Depends on jtm_pkg.
module jtm_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,   // [7:0] rx_byte
	input  logic            s_tlast,
	output logic            frame_valid,
	input  logic            frame_ready,
	output jtm_pkg::frame_t frame
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        last_s1;
	logic [jtm_pkg::POS_W-1:0]   pos_q;
	logic [1:0]                  hdr_q;
	jtm_pkg::cap_t               turn_q;
	jtm_pkg::cap_t               speed_q;

	logic                        adv;
	logic [7:0]                  b;
	logic [1:0]                  hdr_n;
	jtm_pkg::cap_t               turn_n;
	jtm_pkg::cap_t               speed_n;
	jtm_pkg::cap_t               turn_f;
	jtm_pkg::cap_t               speed_f;

	assign adv      = valid_s1 && (!last_s1 || frame_ready);
	assign s_tready = !valid_s1 || adv;

	always_comb begin
		b = (pos_q >= jtm_pkg::POS_W'(jtm_pkg::FRAME_BYTES)) ? jtm_pkg::CH_DOT : byte_s1;
		turn_n  = jtm_pkg::cap_feed(turn_q, b);
		speed_n = jtm_pkg::cap_feed(speed_q, b);
		if (hdr_q == 2'd2 && b == jtm_pkg::CH_C
			&& pos_q < jtm_pkg::POS_W'(jtm_pkg::TURN_START_LIM))
			turn_n.phase = jtm_pkg::PH_SIGN;
		if (b == jtm_pkg::CH_COMMA && pos_q < jtm_pkg::POS_W'(jtm_pkg::START_POSITIONS))
			speed_n.phase = jtm_pkg::PH_SIGN;
		if (b == jtm_pkg::CH_A)
			hdr_n = 2'd1;
		else if (b == jtm_pkg::CH_C && hdr_q == 2'd1)
			hdr_n = 2'd2;
		else
			hdr_n = 2'd0;
		turn_f  = jtm_pkg::cap_finish(turn_n);
		speed_f = jtm_pkg::cap_finish(speed_n);
	end

	assign frame_valid     = valid_s1 && last_s1;
	assign frame.turn      = turn_f.acc;
	assign frame.speed     = speed_f.acc;
	assign frame.turn_pos  = turn_f.sign;
	assign frame.speed_pos = speed_f.sign;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
			hdr_q    <= '0;
			turn_q   <= '0;
			speed_q  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				if (last_s1) begin
					pos_q   <= '0;
					hdr_q   <= '0;
					turn_q  <= '0;
					speed_q <= '0;
				end else begin
					if (pos_q != '1)
						pos_q <= pos_q + 1'b1;
					hdr_q   <= hdr_n;
					turn_q  <= turn_n;
					speed_q <= speed_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> pos_q == '0 && hdr_q == '0 && turn_q.phase == jtm_pkg::PH_IDLE)
		else $error("parser state not cleared after frame end");
	a_held_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> valid_s1 && last_s1)
		else $error("stalled frame end item lost");
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> turn_q.acc <= jtm_pkg::VALUE_W'(jtm_pkg::VALUE_MAX)
			&& speed_q.acc <= jtm_pkg::VALUE_W'(jtm_pkg::VALUE_MAX))
		else $error("capture value beyond saturation");

endmodule

/* sv/jtm_mix.sv */
// Motor mixing of parsed turn and speed into PWM compares, with the result
// register on the master side. Depends on jtm_pkg.
module jtm_mix (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       frame_valid,
	output logic                       frame_ready,
	input  jtm_pkg::frame_t            frame,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [jtm_pkg::OUT_W-1:0]  m_tdata
);

	localparam int PROD_W = 15;

	logic [PROD_W-1:0]          sp20;
	logic [PROD_W-1:0]          tu20;
	logic [PROD_W-1:0]          left_m;
	logic [PROD_W-1:0]          right_m;
	logic [jtm_pkg::PWM_W-1:0]  left_c;
	logic [jtm_pkg::PWM_W-1:0]  right_c;
	logic [jtm_pkg::PWM_W-1:0]  lc;
	logic [jtm_pkg::PWM_W-1:0]  rc;
	logic                       rev;
	logic [jtm_pkg::OUT_W-1:0]  data_n;

	assign frame_ready = !m_tvalid || m_tready;

	always_comb begin
		sp20    = PROD_W'(frame.speed) * PROD_W'(jtm_pkg::PWM_SCALE);
		tu20    = PROD_W'(frame.turn) * PROD_W'(jtm_pkg::PWM_SCALE);
		left_m  = sp20;
		right_m = sp20;
		if (frame.turn < jtm_pkg::VALUE_W'(jtm_pkg::TURN_LIMIT)) begin
			if (!frame.turn_pos)
				left_m = PROD_W'(jtm_pkg::PWM_FULL) - tu20;
			else
				right_m = PROD_W'(jtm_pkg::PWM_FULL) - tu20;
		end
		if (frame.speed > jtm_pkg::VALUE_W'(jtm_pkg::SPEED_LIMIT)) begin
			left_m  = '0;
			right_m = '0;
		end
		left_c  = (left_m > PROD_W'(jtm_pkg::PWM_FULL)) ?
			jtm_pkg::PWM_W'(jtm_pkg::PWM_FULL) : left_m[jtm_pkg::PWM_W-1:0];
		right_c = (right_m > PROD_W'(jtm_pkg::PWM_FULL)) ?
			jtm_pkg::PWM_W'(jtm_pkg::PWM_FULL) : right_m[jtm_pkg::PWM_W-1:0];
		if (frame.speed_pos) begin
			lc  = left_c;
			rc  = right_c;
			rev = 1'b0;
		end else begin
			lc  = (jtm_pkg::PWM_W'(jtm_pkg::PWM_FULL) - left_c) >> 1;
			rc  = (jtm_pkg::PWM_W'(jtm_pkg::PWM_FULL) - right_c) >> 1;
			rev = 1'b1;
		end
		data_n = {2'b00, frame.speed_pos, frame.turn_pos, frame.speed, frame.turn,
			rev, rev, rc, lc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else begin
			if (frame_valid && frame_ready)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready)
			m_tdata <= data_n;
	end

	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:0] <= 11'd2000 && m_tdata[21:11] <= 11'd2000)
		else $error("PWM compare beyond full scale");
	a_rev_pins: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[22] == m_tdata[23] && m_tdata[22] == !m_tdata[45])
		else $error("reverse pins disagree with speed sign");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !frame_ready)
		else $error("result register overwritten while stalled");

endmodule

/* sv/joystick_text_to_motor_pwm.sv */
// Joystick text frame to motor PWM compares.
// Items come in one text byte at a time on the s_ channel; s_tlast marks the
// last byte of a frame. Each frame gives one item on the m_ channel.
// An accepted byte is parsed the cycle after acceptance; the result of a
// frame-end byte goes through the input and result registers to m_tvalid.
// Throughput: one byte per cycle while the result register takes frame ends,
// with no gaps between frames. Timing is set by the parse of the registered
// byte followed by the constant-multiply mix ahead of the result register.
// A stalled result holds m_tdata; bytes keep being taken until a second
// frame end reaches the parser, which then waits for the result register.
// Reset (arst_n low) clears the parser and drops any pending result.
// Parse state also returns to reset after every frame end.
// Uses jtm_parse and jtm_mix; depends on jtm_pkg.
module joystick_text_to_motor_pwm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
	input  logic                       s_tlast,   // frame_end
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [10:0] left_compare, [21:11] right_compare, [22] left_reverse,
	// [23] right_reverse, [33:24] turn_value, [43:34] speed_value,
	// [44] turn_positive, [45] speed_positive, [47:46] zero
	output logic [jtm_pkg::OUT_W-1:0]  m_tdata
);

	logic            frame_valid;
	logic            frame_ready;
	jtm_pkg::frame_t frame;

	jtm_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	jtm_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

/* tb/sv/joystick_text_to_motor_pwm_tb.sv */
// Self-checking bench for joystick_text_to_motor_pwm: feeds text frames byte by byte
// and checks every motor command item against a local parse-and-mix model.
// Depends on jtm_pkg and the joystick_text_to_motor_pwm RTL.
module joystick_text_to_motor_pwm_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		jtm_pkg::phase_t             ph;
		logic [jtm_pkg::VALUE_W-1:0] val;
		logic                        positive;
	} num_capture_t;

	typedef struct packed {
		logic [jtm_pkg::PWM_W-1:0]   left;
		logic [jtm_pkg::PWM_W-1:0]   right;
		logic                        left_rev;
		logic                        right_rev;
		logic [jtm_pkg::VALUE_W-1:0] turn;
		logic [jtm_pkg::VALUE_W-1:0] speed;
		logic                        turn_pos;
		logic                        speed_pos;
	} motor_cmd_t;

	typedef struct {
		logic [7:0] text;
		logic       last;
		bit         drain;
	} rx_item_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [7:0]                s_tdata = 8'h00;
	logic                      s_tlast = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [jtm_pkg::OUT_W-1:0] m_tdata;

	rx_item_t     tx_bytes[$];
	motor_cmd_t   pending_cmds[$];
	int           errors = 0;
	int           results_seen = 0;
	int           frames_sent = 0;

	logic [jtm_pkg::POS_W-1:0] text_pos;
	int                        acc_letters;
	num_capture_t              turn_cap;
	num_capture_t              speed_cap;

	joystick_text_to_motor_pwm i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------- parse and mix model ----------------

	function automatic logic [jtm_pkg::VALUE_W-1:0] append_digit(
		input logic [jtm_pkg::VALUE_W-1:0] v, input logic [7:0] b);
		int t;
		t = int'(v) * 10 + int'(b & jtm_pkg::DIGIT_MASK);
		return (t > jtm_pkg::VALUE_MAX) ? jtm_pkg::VALUE_W'(jtm_pkg::VALUE_MAX) :
			jtm_pkg::VALUE_W'(t);
	endfunction

	function automatic num_capture_t step_capture(input num_capture_t c, input logic [7:0] b);
		num_capture_t n;
		n = c;
		case (c.ph)
			jtm_pkg::PH_SIGN: begin
				if (b == jtm_pkg::CH_MINUS) begin
					n.positive = 1'b0;
					n.ph = jtm_pkg::PH_FIRST;
				end else begin
					n.positive = 1'b1;
					n.val = jtm_pkg::VALUE_W'(b & jtm_pkg::DIGIT_MASK);
					n.ph = jtm_pkg::PH_SECOND;
				end
			end
			jtm_pkg::PH_FIRST: begin
				n.val = jtm_pkg::VALUE_W'(b & jtm_pkg::DIGIT_MASK);
				n.ph = jtm_pkg::PH_SECOND;
			end
			jtm_pkg::PH_SECOND: begin
				if (b == jtm_pkg::CH_DOT) begin
					n.ph = jtm_pkg::PH_IDLE;
				end else begin
					n.val = append_digit(c.val, b);
					n.ph = jtm_pkg::PH_THIRD;
				end
			end
			jtm_pkg::PH_THIRD: begin
				if (b != jtm_pkg::CH_DOT)
					n.val = append_digit(c.val, b);
				n.ph = jtm_pkg::PH_IDLE;
			end
			default: n.ph = jtm_pkg::PH_IDLE;
		endcase
		return n;
	endfunction

	function automatic void clear_parse();
		text_pos = '0;
		acc_letters = 0;
		turn_cap = '{jtm_pkg::PH_IDLE, '0, 1'b0};
		speed_cap = '{jtm_pkg::PH_IDLE, '0, 1'b0};
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] raw, input logic last);
		logic [7:0] b;
		motor_cmd_t cmd;
		int turn;
		int speed;
		int left;
		int right;
		b = (text_pos >= jtm_pkg::FRAME_BYTES) ? jtm_pkg::CH_DOT : raw;
		turn_cap = step_capture(turn_cap, b);
		speed_cap = step_capture(speed_cap, b);
		if (acc_letters == 2 && b == jtm_pkg::CH_C && text_pos < jtm_pkg::TURN_START_LIM)
			turn_cap.ph = jtm_pkg::PH_SIGN;
		if (b == jtm_pkg::CH_COMMA && text_pos < jtm_pkg::START_POSITIONS)
			speed_cap.ph = jtm_pkg::PH_SIGN;
		if (b == jtm_pkg::CH_A)
			acc_letters = 1;
		else if (b == jtm_pkg::CH_C && acc_letters == 1)
			acc_letters = 2;
		else
			acc_letters = 0;
		if (text_pos != '1)
			text_pos = text_pos + 1'b1;
		if (!last)
			return;
		// frame cut short: close open captures as if dots followed
		repeat (4) begin
			turn_cap = step_capture(turn_cap, jtm_pkg::CH_DOT);
			speed_cap = step_capture(speed_cap, jtm_pkg::CH_DOT);
		end
		turn = int'(turn_cap.val);
		speed = int'(speed_cap.val);
		left = speed * jtm_pkg::PWM_SCALE;
		right = left;
		if (turn < jtm_pkg::TURN_LIMIT) begin
			if (!turn_cap.positive)
				left = jtm_pkg::PWM_FULL - turn * jtm_pkg::PWM_SCALE;
			else
				right = jtm_pkg::PWM_FULL - turn * jtm_pkg::PWM_SCALE;
		end
		if (speed > jtm_pkg::SPEED_LIMIT) begin
			left = 0;
			right = 0;
		end
		if (left > jtm_pkg::PWM_FULL)
			left = jtm_pkg::PWM_FULL;
		if (right > jtm_pkg::PWM_FULL)
			right = jtm_pkg::PWM_FULL;
		if (speed_cap.positive) begin
			cmd.left = jtm_pkg::PWM_W'(left);
			cmd.right = jtm_pkg::PWM_W'(right);
		end else begin
			cmd.left = jtm_pkg::PWM_W'((jtm_pkg::PWM_FULL - left) / 2);
			cmd.right = jtm_pkg::PWM_W'((jtm_pkg::PWM_FULL - right) / 2);
		end
		cmd.left_rev = ~speed_cap.positive;
		cmd.right_rev = ~speed_cap.positive;
		cmd.turn = turn_cap.val;
		cmd.speed = speed_cap.val;
		cmd.turn_pos = turn_cap.positive;
		cmd.speed_pos = speed_cap.positive;
		pending_cmds.push_back(cmd);
		clear_parse();
	endfunction

	function automatic void check_field(input string what, input int want, input int seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
			errors++;
		end
	endfunction

	// ---------------- driver ----------------

	int gap = 0;
	int calm_left = 0;
	bit calm_on = 1'b0;

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rx_item_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready && s_tlast)
				frames_sent++;
			if (calm_left == 0) begin
				calm_left = $urandom_range(10, 60);
				calm_on = ($urandom_range(0, 3) == 0);
			end else begin
				calm_left--;
			end
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (tx_bytes.size() > 0 && !tx_bytes[0].drain) begin
					item = tx_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= item.text;
					s_tlast <= item.last;
					gap = calm_on ? 0 : draw_gap();
				end else begin
					s_tvalid <= 1'b0;
					if (tx_bytes.size() > 0 && frames_sent == results_seen)
						void'(tx_bytes.pop_front());
				end
			end
		end
	end

	// ---------------- receiver ready ----------------

	int seg_left = 0;
	int seg_kind = 0;
	int hold_left = 0;
	int holds_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if ((holds_done == 0 && results_seen >= 12) ||
			(holds_done == 1 && results_seen >= 45)) begin
			// long hold-off so the block backs up and stalls its input
			hold_left = 300;
			holds_done++;
			m_tready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(5, 60);
				seg_kind = $urandom_range(0, 9);
			end else begin
				seg_left--;
			end
			if (seg_kind < 4)
				m_tready <= 1'b1;
			else if (seg_kind < 9)
				m_tready <= ($urandom_range(0, 3) != 0);
			else
				m_tready <= 1'b0;
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		motor_cmd_t got;
		motor_cmd_t want;
		if (!arst_n) begin
			clear_parse();
		end else begin
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				got.left = m_tdata[10:0];
				got.right = m_tdata[21:11];
				got.left_rev = m_tdata[22];
				got.right_rev = m_tdata[23];
				got.turn = m_tdata[33:24];
				got.speed = m_tdata[43:34];
				got.turn_pos = m_tdata[44];
				got.speed_pos = m_tdata[45];
				if (pending_cmds.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h", $time,
						m_tdata);
					errors++;
				end else begin
					want = pending_cmds.pop_front();
					check_field("left_compare", want.left, got.left);
					check_field("right_compare", want.right, got.right);
					check_field("left_reverse", want.left_rev, got.left_rev);
					check_field("right_reverse", want.right_rev, got.right_rev);
					check_field("turn_value", want.turn, got.turn);
					check_field("speed_value", want.speed, got.speed);
					check_field("turn_positive", want.turn_pos, got.turn_pos);
					check_field("speed_positive", want.speed_pos, got.speed_pos);
				end
			end
		end
	end

	// ---------------- stimulus ----------------

	task automatic push_byte(input logic [7:0] b, input logic last);
		tx_bytes.push_back('{b, last, 1'b0});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == s.len() - 1);
	endtask

	task automatic push_drain();
		tx_bytes.push_back('{8'h00, 1'b0, 1'b1});
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
			0: return jtm_pkg::CH_A;
			1: return jtm_pkg::CH_C;
			2: return jtm_pkg::CH_MINUS;
			3: return jtm_pkg::CH_DOT;
			4: return jtm_pkg::CH_COMMA;
			5, 6: return 8'h30 + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_field(ref logic [7:0] f[$], input bit is_turn);
		int n;
		if (is_turn) begin
			f.push_back(jtm_pkg::CH_A);
			f.push_back(jtm_pkg::CH_C);
			f.push_back(jtm_pkg::CH_C);
		end else begin
			f.push_back(jtm_pkg::CH_COMMA);
		end
		if ($urandom_range(0, 2) == 0)
			f.push_back(jtm_pkg::CH_MINUS);
		n = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			f.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
				8'h30 + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 7) != 0)
			f.push_back(jtm_pkg::CH_DOT);
	endtask

	task automatic add_random_frame();
		logic [7:0] f[$];
		int len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			len = $urandom_range(1, 7);
		else if (r < 88)
			len = $urandom_range(8, 30);
		else
			len = $urandom_range(31, 45);
		if ($urandom_range(0, 9) < 8) begin
			while (f.size() < len) begin
				r = $urandom_range(0, 9);
				if (r < 3)
					add_field(f, 1'b1);
				else if (r < 6)
					add_field(f, 1'b0);
				else
					f.push_back(noise_byte());
			end
		end else begin
			while (f.size() < len)
				f.push_back(noise_byte());
		end
		foreach (f[i])
			push_byte(f[i], i == f.size() - 1);
	endtask

	initial begin
		int queued;
		int next_drain;
		// directed frames: signs, reverse, open captures, no match, byte extremes
		push_text("acc5.,-30.");
		push_text(",-?");
		push_text("acc");
		push_byte(8'h00, 1'b1);
		push_byte(8'hff, 1'b1);
		push_text(",150.");
		push_drain();
		queued = 23;
		next_drain = 700;
		while (queued < 1450) begin
			add_random_frame();
			queued = 0;
			foreach (tx_bytes[i])
				if (!tx_bytes[i].drain)
					queued++;
			if (queued >= next_drain) begin
				push_drain();
				next_drain += 450;
			end
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (tx_bytes.size() != 0 || s_tvalid || pending_cmds.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_cmds.size() != 0)
			$display("%0t: %0d expected items never arrived", $time, pending_cmds.size());
		if (errors == 0 && pending_cmds.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
